>>> hw/rtl/ffsa_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, codes and types of the first-fit segment allocator.
package ffsa_pkg;

   // default sizes for the top-level parameters
   localparam int MAX_SEGMENTS_DEF = 16;
   localparam int ADDR_WIDTH_DEF   = 16;
   localparam int ID_WIDTH_DEF     = 8;

   // fixed field widths of the request, response and register ports
   localparam int REG_WIDTH      = 16;
   localparam int OWNER_WIDTH    = 8;
   localparam int SIZE_WIDTH     = 16;
   localparam int STATUS_WIDTH   = 3;
   localparam int OUT_ADDR_WIDTH = 16;
   localparam int REQ_DATA_WIDTH = 24;
   localparam int RSP_DATA_WIDTH = 24;

   localparam logic [REG_WIDTH-1:0] TOTAL_SIZE_RESET    = 16'd2560;
   localparam logic [REG_WIDTH-1:0] RESERVED_SIZE_RESET = 16'd400;

   typedef enum logic {
      CSR_TOTAL_SIZE    = 1'b0,
      CSR_RESERVED_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 3'd0,
      ST_NO_FIT    = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_SYSTEM    = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_TAIL,
      FSM_SHIFT_PREP,
      FSM_SHIFT_DOWN,
      FSM_SHIFT_UP,
      FSM_PLACE,
      FSM_DONE
   } state_type;

   // flags from the shared gap/id probe back to the sequencer
   typedef struct packed {
      logic fit;
      logic match;
   } probe_type;

endpackage

>>> hw/rtl/first_fit_segment_allocator_unit.sv
`timescale 1ns / 1ps
// Module: first-fit segment allocator, top level with sequencer and segment table.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  req     | in        | req_tvalid/tready    | tuser: op; tdata: owner_id, request_size
//  rsp     | out       | rsp_tvalid/tready    | tdata: status, start_address
//  csr     | in        | csr_wr_en            | csr_index, csr_wdata (no read-back)
//
// A request runs a scan of one table entry per cycle through the shared probe,
// then moves the entries above the slot one at a time to open or close it, both bound
// by the single read and single write port of the segment table.
// Requests refused on entry (system id, full table, empty table on free) go straight to the done state.
// Reset is synchronous: it empties the table (count to zero) and loads register defaults.
// A finished response waits in the output register; a new request is taken meanwhile,
// and only its completion waits for the output register to free up.
module first_fit_segment_allocator_unit
   import ffsa_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
   parameter int ID_WIDTH     = ID_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request: tdata = owner_id [7:0], request_size [23:8]; tuser = op
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                      req_tuser,
   // response: tdata = status [2:0], start_address [18:3], zero [23:19]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // register writes
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [REG_WIDTH-1:0]      csr_wdata
);

   // datapath wide enough for both the address width and the 16-bit registers
   localparam int DW = (ADDR_WIDTH > REG_WIDTH) ? ADDR_WIDTH : REG_WIDTH;
   localparam int MASK_WIDTH = (ADDR_WIDTH < REG_WIDTH) ? ADDR_WIDTH : REG_WIDTH;
   localparam logic [REG_WIDTH-1:0] FIELD_MASK =
      REG_WIDTH'((64'd1 << MASK_WIDTH) - 64'd1);
   localparam int AIW = $clog2(MAX_SEGMENTS);
   localparam int CW  = $clog2(MAX_SEGMENTS + 1);
   localparam int EW  = ID_WIDTH + 2 * DW;
   localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_SEGMENTS);

   // registers
   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [ID_WIDTH-1:0]  id_ff, id_in;
   logic [DW-1:0]        req_ff, req_in;
   logic [DW:0]          prev_end_ff, prev_end_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        pos_ff, pos_in;
   status_type           status_ff, status_in;
   logic [DW-1:0]        addr_ff, addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [OUT_ADDR_WIDTH-1:0] rsp_addr_ff, rsp_addr_in;
   logic [REG_WIDTH-1:0] total_ff, total_in;
   logic [REG_WIDTH-1:0] reserved_ff, reserved_in;

   // table and probe
   logic                 ram_wr_en;
   logic [AIW-1:0]       ram_wr_addr;
   logic [EW-1:0]        ram_wr_data;
   logic [AIW-1:0]       ram_rd_addr;
   logic [EW-1:0]        ram_rd_data;
   logic [DW-1:0]        rd_size;
   logic [DW-1:0]        rd_start;
   logic [ID_WIDTH-1:0]  rd_id;
   logic [DW-1:0]        probe_start;
   logic [DW:0]          seg_end;
   probe_type            probe;

   // request fields, masked to the configured widths
   op_type               req_op;
   logic [ID_WIDTH-1:0]  req_owner;
   logic [DW-1:0]        req_size;
   logic                 load_rsp;
   logic                 scan_last;

   assign req_op    = op_type'(req_tuser);
   assign req_owner = ID_WIDTH'(req_tdata[OWNER_WIDTH-1:0]);
   assign req_size  = DW'(req_tdata[OWNER_WIDTH +: SIZE_WIDTH] & FIELD_MASK);

   // entry layout: size in the low bits, then start, then owner id
   assign rd_size  = ram_rd_data[DW-1:0];
   assign rd_start = ram_rd_data[2*DW-1:DW];
   assign rd_id    = ram_rd_data[EW-1:2*DW];

   ffsa_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ffsa_probe #(
      .DATA_WIDTH (DW),
      .ID_WIDTH   (ID_WIDTH)
   ) u_probe (
      .seg_start (probe_start),
      .seg_size  (rd_size),
      .seg_id    (rd_id),
      .prev_end  (prev_end_ff),
      .req_size  (req_ff),
      .owner_id  (id_ff),
      .seg_end   (seg_end),
      .probe     (probe)
   );

   // the entry on the read port is the last valid one
   assign scan_last = ((ptr_ff + 1'b1) == count_ff);

   // sequencer: next state, table access and probe operand
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      req_in      = req_ff;
      prev_end_in = prev_end_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      pos_in      = pos_ff;
      status_in   = status_ff;
      addr_in     = addr_ff;
      ram_rd_addr = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = AIW'(ptr_ff + 1'b1);
      ram_wr_data = ram_rd_data;
      probe_start = rd_start;
      req_tready  = 1'b0;
      load_rsp    = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in       = req_op;
               id_in       = req_owner;
               req_in      = req_size;
               prev_end_in = {1'b0, DW'(reserved_ff)};
               ptr_in      = '0;
               addr_in     = '0;
               // entry 0 is on its way through the read port
               if (req_owner == '0) begin
                  status_in = ST_SYSTEM;
                  state_in  = FSM_DONE;
               end else if (req_op == OP_ALLOC && count_ff == COUNT_FULL) begin
                  status_in = ST_FULL;
                  state_in  = FSM_DONE;
               end else if (count_ff == '0) begin
                  if (req_op == OP_ALLOC) begin
                     state_in = FSM_TAIL;
                  end else begin
                     status_in = ST_NOT_FOUND;
                     state_in  = FSM_DONE;
                  end
               end else begin
                  state_in = FSM_SCAN;
               end
            end
         end

         FSM_SCAN: begin
            // fetch the next entry while the probe judges this one
            ram_rd_addr = AIW'(ptr_ff + 1'b1);
            if (op_ff == OP_ALLOC) begin
               if (probe.fit) begin
                  pos_in   = ptr_ff;
                  state_in = FSM_SHIFT_PREP;
               end else begin
                  prev_end_in = seg_end;
                  if (scan_last) begin
                     state_in = FSM_TAIL;
                  end else begin
                     ptr_in = ptr_ff + 1'b1;
                  end
               end
            end else begin
               if (probe.match) begin
                  addr_in = rd_start;
                  if (scan_last) begin
                     count_in  = count_ff - 1'b1;
                     status_in = ST_OK;
                     state_in  = FSM_DONE;
                  end else begin
                     // entry above the match is already being read
                     state_in = FSM_SHIFT_UP;
                  end
               end else if (scan_last) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = FSM_DONE;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end

         FSM_TAIL: begin
            // gap from the last segment end up to total_size
            probe_start = DW'(total_ff);
            if (probe.fit) begin
               pos_in   = count_ff;
               state_in = FSM_PLACE;
            end else begin
               status_in = ST_NO_FIT;
               addr_in   = '0;
               state_in  = FSM_DONE;
            end
         end

         FSM_SHIFT_PREP: begin
            ram_rd_addr = AIW'(count_ff - 1'b1);
            ptr_in      = count_ff - 1'b1;
            state_in    = FSM_SHIFT_DOWN;
         end

         FSM_SHIFT_DOWN: begin
            // move entry ptr up by one, fetch the one below
            ram_wr_en   = 1'b1;
            ram_wr_addr = AIW'(ptr_ff + 1'b1);
            ram_rd_addr = AIW'(ptr_ff - 1'b1);
            if (ptr_ff == pos_ff) begin
               state_in = FSM_PLACE;
            end else begin
               ptr_in = ptr_ff - 1'b1;
            end
         end

         FSM_SHIFT_UP: begin
            // entry ptr+1 is on the read port: move it down to ptr
            ram_wr_en   = 1'b1;
            ram_wr_addr = AIW'(ptr_ff);
            ram_rd_addr = AIW'(ptr_ff + 2'd2);
            if ((ptr_ff + 2'd2) == count_ff) begin
               count_in  = count_ff - 1'b1;
               status_in = ST_OK;
               state_in  = FSM_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         FSM_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AIW'(pos_ff);
            ram_wr_data = {id_ff, prev_end_ff[DW-1:0], req_ff};
            count_in    = count_ff + 1'b1;
            status_in   = ST_OK;
            addr_in     = prev_end_ff[DW-1:0];
            state_in    = FSM_DONE;
         end

         FSM_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // output register: load a finished response, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_addr_in   = (status_ff == ST_OK) ? OUT_ADDR_WIDTH'(addr_ff) : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register writes, data masked to the narrower of the address and register widths
   always_comb begin
      total_in    = total_ff;
      reserved_in = reserved_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TOTAL_SIZE:    total_in    = csr_wdata & FIELD_MASK;
            CSR_RESERVED_SIZE: reserved_in = csr_wdata & FIELD_MASK;
            default: begin
               total_in = total_ff;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= TOTAL_SIZE_RESET;
         reserved_ff  <= RESERVED_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         reserved_ff  <= reserved_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      req_ff        <= req_in;
      prev_end_ff   <= prev_end_in;
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - STATUS_WIDTH - OUT_ADDR_WIDTH){1'b0}},
                        rsp_addr_ff, rsp_status_ff};

`ifndef SYNTH
   // the table never holds more segments than it has entries
   assert property (@(posedge clock) disable iff (reset) count_ff <= COUNT_FULL)
      else $error("segment count beyond table depth");

   // each request adds or removes at most one segment
   assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (count_ff == $past(count_ff) + 1'b1 ||
                              count_ff == $past(count_ff) - 1'b1))
      else $error("segment count jumped by more than one");

   // the table is written only while a request is in progress
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff != FSM_IDLE && state_ff != FSM_DONE))
      else $error("table write outside a request");

   // a refused request leaves the segment count alone
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_DONE && status_ff != ST_OK) |-> $stable(count_ff))
      else $error("segment count changed on a refused request");
`endif

endmodule

>>> hw/rtl/ffsa_ram.sv
`timescale 1ns / 1ps
// Module: generic RAM with one write port and one registered read port.
module ffsa_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ffsa_probe.sv
`timescale 1ns / 1ps
// Module: shared gap compare, segment end adder and id compare.
module ffsa_probe
   import ffsa_pkg::*;
#(
   parameter int DATA_WIDTH = REG_WIDTH,
   parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
   input  logic [DATA_WIDTH-1:0] seg_start,
   input  logic [DATA_WIDTH-1:0] seg_size,
   input  logic [ID_WIDTH-1:0]   seg_id,
   input  logic [DATA_WIDTH:0]   prev_end,
   input  logic [DATA_WIDTH-1:0] req_size,
   input  logic [ID_WIDTH-1:0]   owner_id,
   output logic [DATA_WIDTH:0]   seg_end,
   output probe_type             probe
);

   // signed gap: a zero or negative gap never fits
   logic [DATA_WIDTH+1:0] gap;

   assign gap         = {2'b00, seg_start} - {1'b0, prev_end};
   assign probe.fit   = $signed(gap) > $signed({2'b00, req_size});
   assign probe.match = (seg_id == owner_id);
   assign seg_end     = {1'b0, seg_start} + {1'b0, seg_size};

endmodule

>>> bench/first_fit_segment_allocator_unit_test.sv
`timescale 1ns / 1ps
// Testbench: allocate and free requests through the first-fit segment allocator, every response checked.
module first_fit_segment_allocator_unit_test;
   import ffsa_pkg::*;

   localparam int SEG_DEPTH      = MAX_SEGMENTS_DEF;
   // settle time after the last response, with margin over the longest request
   localparam int SETTLE_CYCLES  = 2 * MAX_SEGMENTS_DEF + 8;
   localparam int STALL_LIMIT    = 20000;
   localparam int PHASE_REQUESTS = 255;
   localparam int POOL_IDS       = 12;

   typedef struct packed {
      status_type                  status;
      logic [OUT_ADDR_WIDTH-1:0]   address;
   } outcome_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;   // owner_id [7:0], request_size [23:8]
   logic                      req_tuser  = 1'b0; // op
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;         // status [2:0], start_address [18:3]
   logic                      csr_wr_en  = 1'b0;
   logic                      csr_index  = 1'b0;
   logic [REG_WIDTH-1:0]      csr_wdata  = '0;

   // shadow of the segment table, ordered by start address
   logic [OWNER_WIDTH-1:0] seg_owner [SEG_DEPTH];
   int                     seg_base  [SEG_DEPTH];
   int                     seg_length[SEG_DEPTH];
   int                     seg_count    = 0;
   int                     mem_total    = int'(TOTAL_SIZE_RESET);
   int                     sys_reserved = int'(RESERVED_SIZE_RESET);

   outcome_type expected_outcomes[$];
   int          errors        = 0;
   int          idle_cycles   = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          rsp_hold_left = 0;

   first_fit_segment_allocator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Apply one request to the shadow table and return the response it must produce.
   // Gaps are signed differences, so a gap that has gone negative after a register
   // change simply never fits.
   function automatic outcome_type book_request(op_type op, logic [OWNER_WIDTH-1:0] owner,
                                                logic [SIZE_WIDTH-1:0] length);
      outcome_type outcome;
      int          prev_end;
      int          slot;
      bit          placed;
      outcome.status  = ST_OK;
      outcome.address = '0;
      if (owner == '0) begin
         outcome.status = ST_SYSTEM;
         return outcome;
      end
      if (op == OP_ALLOC) begin
         if (seg_count >= SEG_DEPTH) begin
            outcome.status = ST_FULL;
            return outcome;
         end
         prev_end = sys_reserved;
         slot     = seg_count;
         placed   = 1'b0;
         for (int i = 0; i < seg_count; i++) begin
            if (!placed) begin
               if (seg_base[i] - prev_end > int'(length)) begin
                  slot   = i;
                  placed = 1'b1;
               end else begin
                  prev_end = seg_base[i] + seg_length[i];
               end
            end
         end
         // the tail gap runs up to total_size; slot already points past the last entry
         if (!placed && (mem_total - prev_end > int'(length)))
            placed = 1'b1;
         if (!placed) begin
            outcome.status = ST_NO_FIT;
            return outcome;
         end
         for (int i = seg_count; i > slot; i--) begin
            seg_owner[i]  = seg_owner[i-1];
            seg_base[i]   = seg_base[i-1];
            seg_length[i] = seg_length[i-1];
         end
         seg_owner[slot]  = owner;
         seg_base[slot]   = prev_end;
         seg_length[slot] = int'(length);
         seg_count++;
         outcome.address = prev_end[OUT_ADDR_WIDTH-1:0];
      end else begin
         // duplicates are allowed: release the lowest-addressed match
         slot = -1;
         for (int i = 0; i < seg_count; i++)
            if (slot < 0 && seg_owner[i] == owner)
               slot = i;
         if (slot < 0) begin
            outcome.status = ST_NOT_FOUND;
            return outcome;
         end
         outcome.address = seg_base[slot][OUT_ADDR_WIDTH-1:0];
         for (int i = slot; i < seg_count - 1; i++) begin
            seg_owner[i]  = seg_owner[i+1];
            seg_base[i]   = seg_base[i+1];
            seg_length[i] = seg_length[i+1];
         end
         seg_count--;
      end
      return outcome;
   endfunction

   // Offer one request from a falling edge, hold it until taken, book its response.
   task automatic send_request(op_type op, logic [OWNER_WIDTH-1:0] owner,
                               logic [SIZE_WIDTH-1:0] length);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {length, owner};
      do @(posedge clock); while (!req_tready);
      expected_outcomes.push_back(book_request(op, owner, length));
      @(negedge clock);
   endtask

   // Pause the sender until every booked response has come back, then let the block settle.
   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (expected_outcomes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register while the block is idle; the extra edge keeps writes apart.
   task automatic write_register(csr_index_type index, logic [REG_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_TOTAL_SIZE)
         mem_total = int'(value);
      else
         sys_reserved = int'(value);
      @(negedge clock);
   endtask

   // System id on either operation, and a free on the empty table.
   task automatic test_refused_requests();
      send_request(OP_ALLOC, 8'h00, 16'd5);
      send_request(OP_FREE, 8'h00, 16'd0);
      send_request(OP_FREE, 8'h07, 16'd0);
   endtask

   // Zero size, largest size, duplicate ids, reuse of a freed hole, strict gap rule.
   task automatic test_fit_rules();
      int last_end;
      int tail;
      send_request(OP_ALLOC, 8'h01, 16'd0);
      send_request(OP_ALLOC, 8'hFF, 16'hFFFF);
      send_request(OP_ALLOC, 8'h02, 16'd100);
      send_request(OP_ALLOC, 8'h02, 16'd50);
      send_request(OP_ALLOC, 8'h03, 16'd10);
      send_request(OP_FREE, 8'h02, 16'd0);
      send_request(OP_ALLOC, 8'h04, 16'd20);
      // a gap exactly the size of the request must be refused, one less must fit
      last_end = (seg_count == 0) ? sys_reserved
                                  : seg_base[seg_count-1] + seg_length[seg_count-1];
      tail = mem_total - last_end;
      if (tail > 1) begin
         send_request(OP_ALLOC, 8'h05, tail[SIZE_WIDTH-1:0]);
         send_request(OP_ALLOC, 8'h05, tail[SIZE_WIDTH-1:0] - 1'b1);
      end
   endtask

   // Fill the table, then one allocate too many and a free of an unknown id.
   task automatic test_table_full();
      for (int k = 0; k < 20 && seg_count < SEG_DEPTH; k++)
         send_request(OP_ALLOC, 8'((k % 8) + 1), 16'd1);
      send_request(OP_ALLOC, 8'h09, 16'd1);
      send_request(OP_FREE, 8'hAA, 16'd0);
   endtask

   // Drain, load a register setting and an idling profile, then run random traffic.
   task automatic test_random_phase(logic [REG_WIDTH-1:0] total, logic [REG_WIDTH-1:0] reserved,
                                    int idle_pct, int stall_pct);
      op_type                 op;
      logic [OWNER_WIDTH-1:0] owner;
      logic [SIZE_WIDTH-1:0]  length;
      int                     span;
      int                     pick;
      wait_all_results();
      write_register(CSR_TOTAL_SIZE, total);
      write_register(CSR_RESERVED_SIZE, reserved);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      span = (mem_total > sys_reserved) ? mem_total - sys_reserved : 1;
      repeat (PHASE_REQUESTS) begin
         if ($urandom_range(0, 99) < 8) begin
            // noise: any op, any id, any size
            op     = op_type'($urandom_range(0, 1));
            owner  = OWNER_WIDTH'($urandom_range(0, 255));
            length = SIZE_WIDTH'($urandom);
         end else begin
            // mostly allocate/free pairs over a small id pool, so frees find their segments
            op    = ($urandom_range(0, 99) < 52) ? OP_ALLOC : OP_FREE;
            owner = OWNER_WIDTH'($urandom_range(1, POOL_IDS));
            pick  = $urandom_range(0, 99);
            if (pick < 70)
               length = SIZE_WIDTH'($urandom_range(0, span / 12));
            else if (pick < 85)
               length = SIZE_WIDTH'($urandom_range(0, span));
            else if (pick < 92)
               length = '0;
            else
               length = SIZE_WIDTH'($urandom_range(span / 2, span));
         end
         send_request(op, owner, length);
      end
   endtask

   // Hold the response side off for a long stretch while requests keep coming,
   // then pause the sender until everything is back and carry on.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 300;
      repeat (12)
         send_request(op_type'($urandom_range(0, 1)), 8'($urandom_range(1, POOL_IDS)),
                      16'($urandom_range(0, 40)));
      wait_all_results();
      repeat (12)
         send_request(op_type'($urandom_range(0, 1)), 8'($urandom_range(1, POOL_IDS)),
                      16'($urandom_range(0, 40)));
   endtask

   // Response side: a long hold when asked, otherwise random stalls at the phase rate.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Compare each response, field by field, with the oldest booked outcome.
   always @(posedge clock) begin
      outcome_type                want;
      logic [STATUS_WIDTH-1:0]    got_status;
      logic [OUT_ADDR_WIDTH-1:0]  got_address;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status  = rsp_tdata[STATUS_WIDTH-1:0];
         got_address = rsp_tdata[STATUS_WIDTH +: OUT_ADDR_WIDTH];
         if (expected_outcomes.size() == 0) begin
            $display("%0t: response with none expected: status %0d address %0d",
                     $time, got_status, got_address);
            errors++;
         end else begin
            want = expected_outcomes.pop_front();
            if (got_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, got_status);
               errors++;
            end
            if (got_address !== want.address) begin
               $display("%0t: start address mismatch: expected %0d actual %0d",
                        $time, want.address, got_address);
               errors++;
            end
         end
      end
   end

   // Watchdog: stop the run if neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_refused_requests();
      test_fit_rules();
      test_table_full();

      // register settings, extremes among them; the table carries over between phases
      test_random_phase(TOTAL_SIZE_RESET, RESERVED_SIZE_RESET, 0, 0);
      test_random_phase(16'hFFFF, 16'h0000, 50, 0);
      test_random_phase(16'd4096, 16'd1024, 0, 50);
      test_random_phase(16'd1, 16'd0, 36, 36);
      test_random_phase(16'd300, 16'hFFFF, 36, 36);
      test_random_phase(16'd800, 16'd100, 50, 50);

      test_back_pressure();

      wait_all_results();
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
